### rtl/core/rgc_pkg.sv
// ----------------------------------------------------------------------------
// rgc_pkg: shared types and constants for the readability grade counter
// Byte classes, grade formula weights, field widths and the control bundle
// passed from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package rgc_pkg;

  // payload widths
  localparam int BYTE_W    = 8;
  localparam int FIELD_W   = 16;
  localparam int GRADE_W   = 5;

  // default tally width
  localparam int COUNT_BITS_DEF = 16;

  // largest value of a 16-bit result field
  localparam int FIELD_MAX = 65535;

  // grade formula weights, all scaled by 100
  localparam int LETTER_MUL = 588;
  localparam int SENT_MUL   = 2960;
  localparam int WORD_MUL   = 1580;
  localparam int DEN_MUL    = 100;

  // top of the grade scale ("16+")
  localparam int GRADE_MAX = 16;

  // quotient bits resolved by the divider, one per cycle
  localparam int QUOT_STEPS = GRADE_W;
  localparam int STEP_W     = $clog2(QUOT_STEPS);

  // character codes
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_PERIOD = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
  localparam logic [BYTE_W-1:0] CH_QUERY  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_UC_A   = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UC_Z   = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LC_A   = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LC_Z   = 8'h7A;

  // sequencer to datapath commands
  typedef struct packed {
    logic count_en;   // a byte beat is taken: update tallies
    logic capture;    // that beat closes the text: latch operands, clear tallies
    logic mul;        // form the weighted products
    logic sum;        // combine products into the signed numerator
    logic prep;       // load divider remainder and divisor
    logic div_step;   // resolve one quotient bit
    logic load_out;   // write the result register
  } cmd_t;

  function automatic logic is_letter(input logic [BYTE_W-1:0] c);
    return ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_term(input logic [BYTE_W-1:0] c);
    return (c == CH_PERIOD) || (c == CH_BANG) || (c == CH_QUERY);
  endfunction

endpackage

### rtl/core/rgc_if.sv
// ----------------------------------------------------------------------------
// rgc_if: valid/ready channels of the readability grade counter
// rgc_in_if carries text bytes, rgc_out_if carries grade results.
// ----------------------------------------------------------------------------
interface rgc_in_if;
  logic                      valid;
  logic                      ready;
  logic [rgc_pkg::BYTE_W-1:0] text_byte;
  logic                      end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface rgc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rgc_pkg::GRADE_W-1:0] grade;
  logic [rgc_pkg::FIELD_W-1:0] letter_total;
  logic [rgc_pkg::FIELD_W-1:0] word_total;
  logic [rgc_pkg::FIELD_W-1:0] sentence_total;

  modport source (output valid, output grade, output letter_total, output word_total,
                  output sentence_total, input ready);
  modport sink   (input valid, input grade, input letter_total, input word_total,
                  input sentence_total, output ready);
endinterface

### rtl/core/rgc_ctrl.sv
// ----------------------------------------------------------------------------
// rgc_ctrl: sequencer of the readability grade counter
// Takes byte beats while counting, then walks the grade computation
// (multiply, sum, divider setup, five divide steps) and loads the result.
// ----------------------------------------------------------------------------
module rgc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_end,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rgc_pkg::cmd_t cmd
);
  import rgc_pkg::*;

  typedef enum logic [2:0] {
    ST_COUNT,
    ST_MUL,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              in_take;
  logic              out_free;

  assign in_ready  = (state_r == ST_COUNT);
  assign in_take   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  // result register can take a new result this cycle
  assign out_free  = !out_valid_r || out_ready;

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.count_en = in_take;
    cmd.capture  = in_take && in_end;
    cmd.mul      = (state_r == ST_MUL);
    cmd.sum      = (state_r == ST_SUM);
    cmd.prep     = (state_r == ST_PREP);
    cmd.div_step = (state_r == ST_DIV);
    cmd.load_out = (state_r == ST_DONE) && out_free;
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_COUNT: begin
        if (in_take && in_end) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_PREP;
      ST_PREP: begin
        step_nxt  = STEP_W'(QUOT_STEPS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_COUNT;
        end
      end
      default: state_nxt = ST_COUNT;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COUNT;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

endmodule

### rtl/core/rgc_datapath.sv
// ----------------------------------------------------------------------------
// rgc_datapath: tallies and grade arithmetic of the readability grade counter
// Saturating byte-class tallies, weighted products, signed numerator and a
// restoring divider that resolves one quotient bit per step.
// ----------------------------------------------------------------------------
module rgc_datapath #(
  parameter int COUNT_BITS = rgc_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rgc_pkg::cmd_t               cmd,
  input  logic [rgc_pkg::BYTE_W-1:0]  text_byte,
  output logic [rgc_pkg::GRADE_W-1:0] grade,
  output logic [rgc_pkg::FIELD_W-1:0] letter_total,
  output logic [rgc_pkg::FIELD_W-1:0] word_total,
  output logic [rgc_pkg::FIELD_W-1:0] sentence_total
);
  import rgc_pkg::*;

  localparam int CB    = COUNT_BITS;
  localparam int PL_W  = CB + 10;   // 588 * letters
  localparam int PS_W  = CB + 12;   // 2960 * sentences
  localparam int PW_W  = CB + 11;   // 1580 * words
  localparam int DEN_W = CB + 7;    // 100 * words
  localparam int NUM_W = CB + 14;   // signed numerator
  localparam int DIV_W = CB + 15;   // 2*|num| + den
  localparam int EXT_W = (CB > FIELD_W) ? CB : FIELD_W;

  // tallies (control state: cleared at reset and after each text)
  logic [CB-1:0] letter_r, letter_nxt;
  logic [CB-1:0] space_r, space_nxt;
  logic [CB-1:0] sent_r, sent_nxt;

  // operands of the text being graded
  logic [CB-1:0] op_l_r, op_w_r, op_s_r;

  logic [PL_W-1:0]  pl_r;
  logic [PS_W-1:0]  ps_r;
  logic [PW_W-1:0]  pw_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] mag;
  logic             neg_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] dsh_r;
  logic [GRADE_W-1:0] quot_r;
  logic             fits;

  logic [GRADE_W-1:0] grade_r;
  logic [FIELD_W-1:0] l_tot_r, w_tot_r, s_tot_r;

  logic [EXT_W-1:0] l_ext, w_ext, s_ext;

  // saturating increment
  function automatic logic [CB-1:0] bump(input logic [CB-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // tally update for the current byte
  always_comb begin
    letter_nxt = letter_r;
    space_nxt  = space_r;
    sent_nxt   = sent_r;
    priority if (is_letter(text_byte)) begin
      letter_nxt = bump(letter_r);
    end else if (is_space(text_byte)) begin
      space_nxt = bump(space_r);
    end else if (is_term(text_byte)) begin
      sent_nxt = bump(sent_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letter_r <= '0;
      space_r  <= '0;
      sent_r   <= '0;
    end else if (cmd.capture) begin
      letter_r <= '0;
      space_r  <= '0;
      sent_r   <= '0;
    end else if (cmd.count_en) begin
      letter_r <= letter_nxt;
      space_r  <= space_nxt;
      sent_r   <= sent_nxt;
    end
  end

  // magnitude of the numerator
  assign mag  = num_r[NUM_W-1] ? (~num_r + 1'b1) : num_r;
  // divisor fits in the remainder
  assign fits = (rem_r >= dsh_r);

  // grade arithmetic
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_l_r <= letter_nxt;
      op_w_r <= bump(space_nxt);
      op_s_r <= sent_nxt;
    end
    if (cmd.mul) begin
      pl_r  <= PL_W'(op_l_r) * PL_W'(LETTER_MUL);
      ps_r  <= PS_W'(op_s_r) * PS_W'(SENT_MUL);
      pw_r  <= PW_W'(op_w_r) * PW_W'(WORD_MUL);
      den_r <= DEN_W'(op_w_r) * DEN_W'(DEN_MUL);
    end
    if (cmd.sum) begin
      num_r <= NUM_W'(pl_r) - NUM_W'(ps_r) - NUM_W'(pw_r);
    end
    // rounding: q = (2|num| + den) / (2 den); divisor starts at (2 den) << 4
    if (cmd.prep) begin
      neg_r  <= num_r[NUM_W-1];
      rem_r  <= (DIV_W'(mag) << 1) + DIV_W'(den_r);
      dsh_r  <= DIV_W'(den_r) << (QUOT_STEPS);
      quot_r <= '0;
    end
    if (cmd.div_step) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      quot_r <= {quot_r[GRADE_W-2:0], fits};
      dsh_r  <= dsh_r >> 1;
    end
    // top quotient bit set means the grade is at least 16
    if (cmd.load_out) begin
      priority if (neg_r) begin
        grade_r <= '0;
      end else if (quot_r[GRADE_W-1]) begin
        grade_r <= GRADE_W'(GRADE_MAX);
      end else begin
        grade_r <= quot_r;
      end
      l_tot_r <= (l_ext > EXT_W'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX) : FIELD_W'(l_ext);
      w_tot_r <= (w_ext > EXT_W'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX) : FIELD_W'(w_ext);
      s_tot_r <= (s_ext > EXT_W'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX) : FIELD_W'(s_ext);
    end
  end

  assign l_ext = EXT_W'(op_l_r);
  assign w_ext = EXT_W'(op_w_r);
  assign s_ext = EXT_W'(op_s_r);

  assign grade          = grade_r;
  assign letter_total   = l_tot_r;
  assign word_total     = w_tot_r;
  assign sentence_total = s_tot_r;

endmodule

### rtl/core/readability_grade_counter.sv
// ----------------------------------------------------------------------------
// readability_grade_counter: Coleman-Liau grade of a byte stream
// Counts letters, whitespace and sentence ends and grades each text.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one text byte per beat; end_of_text marks the last byte,
//          which is counted like the others.
//   out_ch gives one result per text: grade (0..16) and the letter, word
//          and sentence totals, each clipped to 16 bits.
// Sequence: ordinary bytes are counted as they are taken. The last byte
//   of a text starts the grade computation: a multiply state, a sum state,
//   a divider setup state and a divide step for each quotient bit of the
//   restoring divider, then the result is loaded. in_ch.ready is low from
//   the last byte until the result is loaded, so the next text waits.
// Stall: the result register holds until out_ch takes it; counting of the
//   next text continues meanwhile, and a further last byte waits in the
//   load cycle until the register is free.
// Reset: synchronous active-low rst_n clears the tallies, the sequencer and
//   out_ch.valid.
// ----------------------------------------------------------------------------
module readability_grade_counter #(
  parameter int COUNT_BITS = rgc_pkg::COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rgc_in_if.sink    in_ch,
  rgc_out_if.source out_ch
);
  import rgc_pkg::*;

  cmd_t cmd;
  logic in_ready;
  logic out_valid;

  rgc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_end    (in_ch.end_of_text),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  rgc_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .text_byte      (in_ch.text_byte),
    .grade          (out_ch.grade),
    .letter_total   (out_ch.letter_total),
    .word_total     (out_ch.word_total),
    .sentence_total (out_ch.sentence_total)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // no byte beat is taken while a grade is in flight
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.end_of_text) |=> !in_ch.ready)
    else $error("byte taken right after end of text");

  // grade stays on its scale
  a_grade_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.grade <= GRADE_W'(GRADE_MAX)))
    else $error("grade above 16");

  // every text has at least one word
  a_word_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.word_total != '0))
    else $error("word total of zero");

endmodule
